@@ sv/tstty_pkg.sv @@
`timescale 1ns / 1ps
// shared constants, codes, control word types and helper functions for the
// typesetting-directive to terminal byte converter; no dependencies
package tstty_pkg;

    localparam int TABLE_ENTRIES_DEF = 99;

    localparam int H_LIMIT   = 360;
    localparam int V_LIMIT   = 200;
    localparam int PH_W      = 10;   // pending horizontal, -360..360
    localparam int PV_W      = 9;    // pending vertical, -200..200
    localparam int COL_W     = 16;
    localparam int CNT_W     = 5;    // run lengths up to 30

    // directive kinds
    localparam logic [2:0] KIND_IGNORE = 3'd0;
    localparam logic [2:0] KIND_HMOVE  = 3'd1;
    localparam logic [2:0] KIND_VMOVE  = 3'd2;
    localparam logic [2:0] KIND_STYLE  = 3'd3;
    localparam logic [2:0] KIND_BREAK  = 3'd4;
    localparam logic [2:0] KIND_CHAR   = 3'd5;
    localparam logic [2:0] KIND_HYPHEN = 3'd6;

    // terminal bytes
    localparam logic [7:0] BYTE_ESC    = 8'h1B;
    localparam logic [7:0] BYTE_DOWN   = 8'h42;  // 'B'
    localparam logic [7:0] BYTE_HDOWN  = 8'h39;  // '9'
    localparam logic [7:0] BYTE_HUP    = 8'h38;  // '8'
    localparam logic [7:0] BYTE_UP     = 8'h37;  // '7'
    localparam logic [7:0] BYTE_SPACE  = 8'h20;
    localparam logic [7:0] BYTE_BS     = 8'h08;
    localparam logic [7:0] BYTE_NL     = 8'h0A;
    localparam logic [7:0] BYTE_CR     = 8'h0D;
    localparam logic [7:0] BYTE_UNDER  = 8'h5F;
    localparam logic [7:0] BYTE_HYPHEN = 8'h2D;

    // microprogram steps
    localparam int STEP_W = 4;
    localparam logic [STEP_W-1:0] ST_IDLE   = 4'd0;
    localparam logic [STEP_W-1:0] ST_CH_DIV = 4'd1;
    localparam logic [STEP_W-1:0] ST_V_ESC  = 4'd2;
    localparam logic [STEP_W-1:0] ST_V_DIR  = 4'd3;
    localparam logic [STEP_W-1:0] ST_HF_ESC = 4'd4;
    localparam logic [STEP_W-1:0] ST_HF_DIR = 4'd5;
    localparam logic [STEP_W-1:0] ST_HMOV   = 4'd6;
    localparam logic [STEP_W-1:0] ST_OVR    = 4'd7;
    localparam logic [STEP_W-1:0] ST_OBS    = 4'd8;
    localparam logic [STEP_W-1:0] ST_GLY    = 4'd9;
    localparam logic [STEP_W-1:0] ST_LB_DIV = 4'd10;
    localparam logic [STEP_W-1:0] ST_NL     = 4'd11;
    localparam logic [STEP_W-1:0] ST_CR     = 4'd12;
    localparam logic [STEP_W-1:0] ST_UESC   = 4'd13;
    localparam logic [STEP_W-1:0] ST_USEV   = 4'd14;
    localparam logic [STEP_W-1:0] ST_BAD    = 4'd15;

    // byte selects
    localparam int SEL_W = 4;
    localparam logic [SEL_W-1:0] SEL_ZERO  = 4'd0;
    localparam logic [SEL_W-1:0] SEL_ESC   = 4'd1;
    localparam logic [SEL_W-1:0] SEL_VERT  = 4'd2;
    localparam logic [SEL_W-1:0] SEL_HALF  = 4'd3;
    localparam logic [SEL_W-1:0] SEL_HMOVE = 4'd4;
    localparam logic [SEL_W-1:0] SEL_OVER  = 4'd5;
    localparam logic [SEL_W-1:0] SEL_BS    = 4'd6;
    localparam logic [SEL_W-1:0] SEL_GLYPH = 4'd7;
    localparam logic [SEL_W-1:0] SEL_NL    = 4'd8;
    localparam logic [SEL_W-1:0] SEL_CR    = 4'd9;
    localparam logic [SEL_W-1:0] SEL_SEVEN = 4'd10;

    // datapath operations
    localparam int OP_W = 3;
    localparam logic [OP_W-1:0] OP_NONE   = 3'd0;
    localparam logic [OP_W-1:0] OP_CH_DIV = 3'd1;
    localparam logic [OP_W-1:0] OP_LOAD_H = 3'd2;
    localparam logic [OP_W-1:0] OP_FINISH = 3'd3;
    localparam logic [OP_W-1:0] OP_LB_DIV = 3'd4;

    // sequencing conditions
    localparam int COND_W = 3;
    localparam logic [COND_W-1:0] COND_NEXT      = 3'd0;
    localparam logic [COND_W-1:0] COND_SKIPZ     = 3'd1;
    localparam logic [COND_W-1:0] COND_LOOP      = 3'd2;
    localparam logic [COND_W-1:0] COND_SKIPHALF  = 3'd3;
    localparam logic [COND_W-1:0] COND_SKIPPLAIN = 3'd4;
    localparam logic [COND_W-1:0] COND_SKIPPOS   = 3'd5;
    localparam logic [COND_W-1:0] COND_REPEAT    = 3'd6;

    // last-of-run marking
    localparam logic [1:0] LAST_NO   = 2'd0;
    localparam logic [1:0] LAST_YES  = 2'd1;
    localparam logic [1:0] LAST_CNT0 = 2'd2;
    localparam logic [1:0] LAST_CNT1 = 2'd3;

    typedef struct packed {
        logic [SEL_W-1:0]  sel;
        logic              emit;
        logic [COND_W-1:0] cond;
        logic [1:0]        last;
        logic              bad;
        logic [OP_W-1:0]   op;
        logic [STEP_W-1:0] target;
        logic [STEP_W-1:0] next;
    } t_uword;

    typedef struct packed {
        logic cnt_zero;
        logic cnt_one;
        logic half;
        logic styled;
        logic pv_neg;
    } t_flags;

    typedef struct packed {
        logic             emit;
        logic             dec;
        logic             last;
        logic             bad;
        logic [SEL_W-1:0] sel;
        logic [OP_W-1:0]  op;
    } t_act;

    // floor(x / 20) for x up to 215
    function automatic logic [3:0] div20(input logic [7:0] x);
        logic [15:0] p;
        p = 16'(x) * 16'd205;
        return p[15:12];
    endfunction

    // floor(x / 12) for x up to 366
    function automatic logic [4:0] div12(input logic [8:0] x);
        logic [17:0] p;
        p = 18'(x) * 18'd171;
        return p[15:11];
    endfunction

    function automatic logic signed [PH_W-1:0] sat_ph(input logic signed [11:0] v);
        logic signed [11:0] hi;
        hi = 12'(H_LIMIT);
        if (v > hi) begin
            return hi[PH_W-1:0];
        end else if (v < -hi) begin
            return 10'(-hi);
        end
        return v[PH_W-1:0];
    endfunction

    function automatic logic signed [PV_W-1:0] sat_pv(input logic signed [9:0] v);
        logic signed [9:0] hi;
        hi = 10'(V_LIMIT);
        if (v > hi) begin
            return hi[PV_W-1:0];
        end else if (v < -hi) begin
            return 9'(-hi);
        end
        return v[PV_W-1:0];
    endfunction

    function automatic logic is_alnum(input logic [7:0] c);
        return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
               (c >= 8'h61 && c <= 8'h7A);
    endfunction

    // character rom, unused codes give zero
    function automatic logic [7:0] glyph_rom(input logic [6:0] code);
        logic [7:0] c;
        c = {1'b0, code};
        if (code >= 7'd1 && code <= 7'd10) begin
            return 8'h30 + (c - 8'd1);
        end else if (code >= 7'd11 && code <= 7'd36) begin
            return 8'h41 + (c - 8'd11);
        end else if (code >= 7'd37 && code <= 7'd62) begin
            return 8'h61 + (c - 8'd37);
        end
        case (code)
            7'd63:   return 8'h21;
            7'd64:   return 8'h22;
            7'd65:   return 8'h23;
            7'd66:   return 8'h24;
            7'd67:   return 8'h25;
            7'd68:   return 8'h26;
            7'd69:   return 8'h28;
            7'd70:   return 8'h29;
            7'd71:   return 8'h2A;
            7'd72:   return 8'h2B;
            7'd73:   return 8'h2C;
            7'd74:   return 8'h2D;
            7'd75:   return 8'h2E;
            7'd76:   return 8'h2F;
            7'd77:   return 8'h3A;
            7'd78:   return 8'h3B;
            7'd79:   return 8'h3C;
            7'd80:   return 8'h3D;
            7'd81:   return 8'h3E;
            7'd82:   return 8'h3F;
            7'd83:   return 8'h40;
            7'd84:   return 8'h5B;
            7'd85:   return 8'h5C;
            7'd86:   return 8'h5D;
            7'd87:   return 8'h5E;
            7'd88:   return 8'h5F;
            7'd89:   return 8'h7B;
            7'd90:   return 8'h7C;
            7'd91:   return 8'h7D;
            7'd92:   return 8'h7E;
            7'd93:   return 8'h60;
            7'd94:   return 8'h27;
            7'd95:   return 8'h27;
            7'd96:   return 8'h60;
            7'd97:   return 8'h5E;
            7'd98:   return 8'h2D;
            default: return 8'h00;
        endcase
    endfunction

endpackage

@@ sv/tstty_if.sv @@
`timescale 1ns / 1ps
// valid/ready channel interfaces: directive input and terminal byte output
// no dependencies
interface tstty_in_if;
    logic              valid;
    logic              ready;
    logic [2:0]        kind;
    logic signed [8:0] move_amount;
    logic [6:0]        char_code;
    logic [7:0]        advance;
    logic              set_bold;
    logic              set_italic;

    modport source (output valid, kind, move_amount, char_code, advance, set_bold,
                    set_italic, input ready);
    modport sink (input valid, kind, move_amount, char_code, advance, set_bold,
                  set_italic, output ready);
endinterface

interface tstty_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last_of_run;
    logic       bad_code;

    modport source (output valid, out_byte, last_of_run, bad_code, input ready);
    modport sink (input valid, out_byte, last_of_run, bad_code, output ready);
endinterface

@@ sv/tstty_seq.sv @@
`timescale 1ns / 1ps
// microprogram sequencer: step counter, control store and branch resolution
// depends on tstty_pkg
module tstty_seq (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [tstty_pkg::STEP_W-1:0] i_entry,
    input  logic                         i_go,
    input  tstty_pkg::t_flags            i_flags,
    output tstty_pkg::t_act              o_act,
    output logic                         o_idle
);

    logic [tstty_pkg::STEP_W-1:0] r_step;
    logic [tstty_pkg::STEP_W-1:0] n_step;
    logic [tstty_pkg::STEP_W-1:0] w_nxt;
    tstty_pkg::t_uword            w_uw;
    logic                         w_skip;
    logic                         w_dec;
    logic                         w_last;

    function automatic tstty_pkg::t_uword mk(
        input logic [tstty_pkg::SEL_W-1:0]  sel,
        input logic                         emit,
        input logic [tstty_pkg::COND_W-1:0] cond,
        input logic [1:0]                   last,
        input logic                         bad,
        input logic [tstty_pkg::OP_W-1:0]   op,
        input logic [tstty_pkg::STEP_W-1:0] target,
        input logic [tstty_pkg::STEP_W-1:0] next
    );
        tstty_pkg::t_uword u;
        u.sel    = sel;
        u.emit   = emit;
        u.cond   = cond;
        u.last   = last;
        u.bad    = bad;
        u.op     = op;
        u.target = target;
        u.next   = next;
        return u;
    endfunction

    // control store
    function automatic tstty_pkg::t_uword urom(input logic [tstty_pkg::STEP_W-1:0] s);
        case (s)
            tstty_pkg::ST_CH_DIV: return mk(tstty_pkg::SEL_ZERO, 1'b0, tstty_pkg::COND_NEXT,
                tstty_pkg::LAST_NO, 1'b0, tstty_pkg::OP_CH_DIV, tstty_pkg::ST_IDLE,
                tstty_pkg::ST_V_ESC);
            tstty_pkg::ST_V_ESC: return mk(tstty_pkg::SEL_ESC, 1'b1, tstty_pkg::COND_SKIPZ,
                tstty_pkg::LAST_NO, 1'b0, tstty_pkg::OP_NONE, tstty_pkg::ST_HF_ESC,
                tstty_pkg::ST_V_DIR);
            tstty_pkg::ST_V_DIR: return mk(tstty_pkg::SEL_VERT, 1'b1, tstty_pkg::COND_LOOP,
                tstty_pkg::LAST_NO, 1'b0, tstty_pkg::OP_NONE, tstty_pkg::ST_V_ESC,
                tstty_pkg::ST_HF_ESC);
            tstty_pkg::ST_HF_ESC: return mk(tstty_pkg::SEL_ESC, 1'b1,
                tstty_pkg::COND_SKIPHALF, tstty_pkg::LAST_NO, 1'b0, tstty_pkg::OP_LOAD_H,
                tstty_pkg::ST_HMOV, tstty_pkg::ST_HF_DIR);
            tstty_pkg::ST_HF_DIR: return mk(tstty_pkg::SEL_HALF, 1'b1, tstty_pkg::COND_NEXT,
                tstty_pkg::LAST_NO, 1'b0, tstty_pkg::OP_NONE, tstty_pkg::ST_IDLE,
                tstty_pkg::ST_HMOV);
            tstty_pkg::ST_HMOV: return mk(tstty_pkg::SEL_HMOVE, 1'b1, tstty_pkg::COND_REPEAT,
                tstty_pkg::LAST_NO, 1'b0, tstty_pkg::OP_NONE, tstty_pkg::ST_OVR,
                tstty_pkg::ST_HMOV);
            tstty_pkg::ST_OVR: return mk(tstty_pkg::SEL_OVER, 1'b1,
                tstty_pkg::COND_SKIPPLAIN, tstty_pkg::LAST_NO, 1'b0, tstty_pkg::OP_NONE,
                tstty_pkg::ST_GLY, tstty_pkg::ST_OBS);
            tstty_pkg::ST_OBS: return mk(tstty_pkg::SEL_BS, 1'b1, tstty_pkg::COND_NEXT,
                tstty_pkg::LAST_NO, 1'b0, tstty_pkg::OP_NONE, tstty_pkg::ST_IDLE,
                tstty_pkg::ST_GLY);
            tstty_pkg::ST_GLY: return mk(tstty_pkg::SEL_GLYPH, 1'b1, tstty_pkg::COND_NEXT,
                tstty_pkg::LAST_YES, 1'b0, tstty_pkg::OP_FINISH, tstty_pkg::ST_IDLE,
                tstty_pkg::ST_IDLE);
            tstty_pkg::ST_LB_DIV: return mk(tstty_pkg::SEL_ZERO, 1'b0,
                tstty_pkg::COND_SKIPPOS, tstty_pkg::LAST_NO, 1'b0, tstty_pkg::OP_LB_DIV,
                tstty_pkg::ST_NL, tstty_pkg::ST_CR);
            tstty_pkg::ST_NL: return mk(tstty_pkg::SEL_NL, 1'b1, tstty_pkg::COND_REPEAT,
                tstty_pkg::LAST_CNT1, 1'b0, tstty_pkg::OP_NONE, tstty_pkg::ST_IDLE,
                tstty_pkg::ST_NL);
            tstty_pkg::ST_CR: return mk(tstty_pkg::SEL_CR, 1'b1, tstty_pkg::COND_NEXT,
                tstty_pkg::LAST_CNT0, 1'b0, tstty_pkg::OP_NONE, tstty_pkg::ST_IDLE,
                tstty_pkg::ST_UESC);
            tstty_pkg::ST_UESC: return mk(tstty_pkg::SEL_ESC, 1'b1, tstty_pkg::COND_SKIPZ,
                tstty_pkg::LAST_NO, 1'b0, tstty_pkg::OP_NONE, tstty_pkg::ST_IDLE,
                tstty_pkg::ST_USEV);
            tstty_pkg::ST_USEV: return mk(tstty_pkg::SEL_SEVEN, 1'b1, tstty_pkg::COND_LOOP,
                tstty_pkg::LAST_CNT1, 1'b0, tstty_pkg::OP_NONE, tstty_pkg::ST_UESC,
                tstty_pkg::ST_IDLE);
            tstty_pkg::ST_BAD: return mk(tstty_pkg::SEL_ZERO, 1'b1, tstty_pkg::COND_NEXT,
                tstty_pkg::LAST_YES, 1'b1, tstty_pkg::OP_NONE, tstty_pkg::ST_IDLE,
                tstty_pkg::ST_IDLE);
            default: return mk(tstty_pkg::SEL_ZERO, 1'b0, tstty_pkg::COND_NEXT,
                tstty_pkg::LAST_NO, 1'b0, tstty_pkg::OP_NONE, tstty_pkg::ST_IDLE,
                tstty_pkg::ST_IDLE);
        endcase
    endfunction

    always_comb begin
        w_uw   = urom(r_step);
        w_skip = 1'b0;
        w_dec  = 1'b0;
        w_nxt  = w_uw.next;
        case (w_uw.cond)
            tstty_pkg::COND_NEXT: begin
                w_nxt = w_uw.next;
            end
            tstty_pkg::COND_SKIPZ: begin
                if (i_flags.cnt_zero) begin
                    w_skip = 1'b1;
                    w_nxt  = w_uw.target;
                end
            end
            tstty_pkg::COND_LOOP: begin
                w_dec = 1'b1;
                w_nxt = i_flags.cnt_one ? w_uw.next : w_uw.target;
            end
            tstty_pkg::COND_SKIPHALF: begin
                if (!i_flags.half) begin
                    w_skip = 1'b1;
                    w_nxt  = w_uw.target;
                end
            end
            tstty_pkg::COND_SKIPPLAIN: begin
                if (!i_flags.styled) begin
                    w_skip = 1'b1;
                    w_nxt  = w_uw.target;
                end
            end
            tstty_pkg::COND_SKIPPOS: begin
                if (!i_flags.pv_neg) begin
                    w_skip = 1'b1;
                    w_nxt  = w_uw.target;
                end
            end
            tstty_pkg::COND_REPEAT: begin
                // emit cnt times, possibly none, then leave for target
                if (i_flags.cnt_zero) begin
                    w_skip = 1'b1;
                    w_nxt  = w_uw.target;
                end else begin
                    w_dec = 1'b1;
                    w_nxt = i_flags.cnt_one ? w_uw.target : r_step;
                end
            end
            default: begin
                w_nxt = w_uw.next;
            end
        endcase

        case (w_uw.last)
            tstty_pkg::LAST_YES:  w_last = 1'b1;
            tstty_pkg::LAST_CNT0: w_last = i_flags.cnt_zero;
            tstty_pkg::LAST_CNT1: w_last = i_flags.cnt_one;
            default:              w_last = 1'b0;
        endcase

        o_act.emit = w_uw.emit && !w_skip;
        o_act.dec  = w_dec;
        o_act.last = w_last;
        o_act.bad  = w_uw.bad;
        o_act.sel  = w_uw.sel;
        o_act.op   = w_uw.op;

        if (r_step == tstty_pkg::ST_IDLE) begin
            n_step = i_start ? i_entry : tstty_pkg::ST_IDLE;
        end else if (i_go) begin
            n_step = w_nxt;
        end else begin
            n_step = r_step;
        end
    end

    assign o_idle = (r_step == tstty_pkg::ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= tstty_pkg::ST_IDLE;
        end else begin
            r_step <= n_step;
        end
    end

endmodule

@@ sv/typeset_stream_to_tty_bytes.sv @@
`timescale 1ns / 1ps
// Typesetting directive stream to terminal byte converter.
// i_in carries one directive per transaction; o_out carries one terminal byte per
// transaction, with last_of_run on the final byte a directive causes and
// bad_code on the single error byte of an out-of-range character code.
// Motion, style and ignored directives are absorbed in the accept cycle and
// give no bytes. A line break or a character is run by a microprogram: one
// step per cycle while o_out is not stalled, at most one byte per step. A
// character is accepted and divided, then runs the vertical, half-step,
// horizontal and overstrike sections and sends its glyph; a section that sends
// nothing still takes a step. A line break is accepted and divided, then sends
// its bytes, plus a step when nothing or only the carriage return is sent.
// The step rate is set by the single output register, which holds one byte.
// i_in.ready is high whenever the sequencer is idle, even while the last byte
// still waits in the output register. A stall on o_out freezes the
// sequencer on its current step; nothing is dropped.
// Reset clears pending motion, column, style and the output valid, and
// returns the sequencer to idle.
// depends on tstty_pkg, tstty_if, tstty_seq
module typeset_stream_to_tty_bytes #(
    parameter int TABLE_ENTRIES = tstty_pkg::TABLE_ENTRIES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    tstty_in_if.sink           i_in,
    tstty_out_if.source        o_out
);

    localparam logic [7:0] CODE_LIMIT = 8'(TABLE_ENTRIES);

    // architectural state
    logic signed [tstty_pkg::PH_W-1:0] r_ph;
    logic signed [tstty_pkg::PV_W-1:0] r_pv;
    logic [tstty_pkg::COL_W-1:0]       r_col;
    logic                              r_bold;
    logic                              r_italic;

    // run working registers
    logic [tstty_pkg::CNT_W-1:0] r_cnt;
    logic [tstty_pkg::CNT_W-1:0] r_hcnt;
    logic                        r_half;
    logic                        r_up;
    logic                        r_left;
    logic [7:0]                  r_glyph;
    logic [7:0]                  r_adv;
    logic                        r_styled;

    // output register
    logic       r_ovalid;
    logic [7:0] r_obyte;
    logic       r_olast;
    logic       r_obad;

    logic                         w_go;
    logic                         w_acc;
    logic                         w_idle;
    logic                         w_bad_code;
    logic [tstty_pkg::STEP_W-1:0] w_entry;
    logic [7:0]                   w_glyph_in;
    tstty_pkg::t_act              w_act;
    tstty_pkg::t_flags            w_flags;
    logic [7:0]                   w_byte;

    logic signed [8:0]  w_amt;
    logic signed [11:0] w_hm_ph;
    logic signed [11:0] w_hm_ph_adj;
    logic signed [17:0] w_hm_pos;
    logic [tstty_pkg::COL_W-1:0] w_hm_col;
    logic signed [9:0]  w_pv_add;

    logic signed [9:0]  w_pv_ext;
    logic signed [9:0]  w_lb_x;
    logic signed [9:0]  w_cv_x;
    logic [7:0]         w_d20_x;
    logic [3:0]         w_d20_q;
    logic [7:0]         w_d20_r;
    logic signed [9:0]  w_q20;
    logic signed [9:0]  w_lb_pv;

    logic signed [10:0] w_ph_ext;
    logic signed [10:0] w_h_x;
    logic [4:0]         w_d12_q;
    logic signed [10:0] w_q12;
    logic signed [10:0] w_ch_ph;

    logic signed [11:0] w_fin_ph;
    logic [16:0]        w_fin_col;

    assign w_acc  = i_in.valid && w_idle;
    assign w_go   = !r_ovalid || o_out.ready;
    assign i_in.ready = w_idle;

    assign o_out.valid       = r_ovalid;
    assign o_out.out_byte    = r_obyte;
    assign o_out.last_of_run = r_olast;
    assign o_out.bad_code    = r_obad;

    assign w_bad_code = (i_in.char_code == 7'd0) || ({1'b0, i_in.char_code} >= CODE_LIMIT);
    assign w_glyph_in = (i_in.kind == tstty_pkg::KIND_HYPHEN) ? tstty_pkg::BYTE_HYPHEN :
                        tstty_pkg::glyph_rom(i_in.char_code);

    always_comb begin
        case (i_in.kind)
            tstty_pkg::KIND_BREAK:  w_entry = tstty_pkg::ST_LB_DIV;
            tstty_pkg::KIND_CHAR:   w_entry = w_bad_code ? tstty_pkg::ST_BAD :
                                              tstty_pkg::ST_CH_DIV;
            tstty_pkg::KIND_HYPHEN: w_entry = tstty_pkg::ST_CH_DIV;
            default:                w_entry = tstty_pkg::ST_IDLE;
        endcase
    end

    assign w_flags.cnt_zero = (r_cnt == '0);
    assign w_flags.cnt_one  = (r_cnt == 5'd1);
    assign w_flags.half     = r_half;
    assign w_flags.styled   = r_styled;
    assign w_flags.pv_neg   = r_pv[tstty_pkg::PV_W-1];

    tstty_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_acc),
        .i_entry (w_entry),
        .i_go    (w_go),
        .i_flags (w_flags),
        .o_act   (w_act),
        .o_idle  (w_idle)
    );

    // motion directives at accept
    assign w_amt    = i_in.move_amount;
    assign w_hm_ph  = {{2{r_ph[9]}}, r_ph} + {{3{w_amt[8]}}, w_amt};
    assign w_hm_pos = $signed({2'b00, r_col}) + {{9{w_amt[8]}}, w_amt};
    // a column pushed below zero hands the excess back to pending motion
    assign w_hm_ph_adj = w_hm_pos[17] ? (w_hm_ph - $signed(w_hm_pos[11:0])) : w_hm_ph;
    assign w_hm_col = w_hm_pos[17] ? '0 : (w_hm_pos[16] ? '1 : w_hm_pos[15:0]);
    assign w_pv_add = {r_pv[8], r_pv} + {w_amt[8], w_amt};

    // shared divide by 20: line break rounding or vertical flush
    assign w_pv_ext = {r_pv[8], r_pv};
    assign w_lb_x   = r_pv[8] ? (10'sd9 - w_pv_ext) : (w_pv_ext + 10'sd10);
    assign w_cv_x   = r_pv[8] ? (10'sd5 - w_pv_ext) : (w_pv_ext + 10'sd5);
    assign w_d20_x  = (w_act.op == tstty_pkg::OP_LB_DIV) ? w_lb_x[7:0] : w_cv_x[7:0];
    assign w_d20_q  = tstty_pkg::div20(w_d20_x);
    assign w_d20_r  = w_d20_x - 8'(w_d20_q) * 8'd20;
    assign w_q20    = $signed(10'(w_d20_q) * 10'd20);
    assign w_lb_pv  = r_pv[8] ? (w_pv_ext + w_q20) : (w_pv_ext - w_q20);

    // horizontal flush in whole columns
    assign w_ph_ext = {r_ph[9], r_ph};
    assign w_h_x    = r_ph[9] ? (11'sd5 - w_ph_ext) : (w_ph_ext + 11'sd6);
    assign w_d12_q  = tstty_pkg::div12(w_h_x[8:0]);
    assign w_q12    = $signed(11'(w_d12_q) * 11'd12);
    assign w_ch_ph  = r_ph[9] ? (w_ph_ext + w_q12) : (w_ph_ext - w_q12);

    assign w_fin_ph  = {{2{r_ph[9]}}, r_ph} + $signed({4'b0000, r_adv}) - 12'sd12;
    assign w_fin_col = {1'b0, r_col} + {9'd0, r_adv};

    always_comb begin
        case (w_act.sel)
            tstty_pkg::SEL_ESC:   w_byte = tstty_pkg::BYTE_ESC;
            tstty_pkg::SEL_VERT:  w_byte = r_up ? tstty_pkg::BYTE_UP : tstty_pkg::BYTE_DOWN;
            tstty_pkg::SEL_HALF:  w_byte = r_up ? tstty_pkg::BYTE_HUP : tstty_pkg::BYTE_HDOWN;
            tstty_pkg::SEL_HMOVE: w_byte = r_left ? tstty_pkg::BYTE_BS : tstty_pkg::BYTE_SPACE;
            tstty_pkg::SEL_OVER:  w_byte = r_italic ? tstty_pkg::BYTE_UNDER : r_glyph;
            tstty_pkg::SEL_BS:    w_byte = tstty_pkg::BYTE_BS;
            tstty_pkg::SEL_GLYPH: w_byte = r_glyph;
            tstty_pkg::SEL_NL:    w_byte = tstty_pkg::BYTE_NL;
            tstty_pkg::SEL_CR:    w_byte = tstty_pkg::BYTE_CR;
            tstty_pkg::SEL_SEVEN: w_byte = tstty_pkg::BYTE_UP;
            default:              w_byte = 8'h00;
        endcase
    end

    // control and architectural state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph     <= '0;
            r_pv     <= '0;
            r_col    <= '0;
            r_bold   <= 1'b0;
            r_italic <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (w_go) begin
                r_ovalid <= w_act.emit;
            end
            if (w_acc) begin
                case (i_in.kind)
                    tstty_pkg::KIND_HMOVE: begin
                        r_ph  <= tstty_pkg::sat_ph(w_hm_ph_adj);
                        r_col <= w_hm_col;
                    end
                    tstty_pkg::KIND_VMOVE: begin
                        r_pv <= tstty_pkg::sat_pv(w_pv_add);
                    end
                    tstty_pkg::KIND_STYLE: begin
                        r_bold   <= i_in.set_bold;
                        r_italic <= i_in.set_italic;
                    end
                    tstty_pkg::KIND_BREAK: begin
                        r_col <= '0;
                        r_ph  <= '0;
                        r_pv  <= tstty_pkg::sat_pv(w_pv_add);
                    end
                    default: begin
                        r_col <= r_col;
                    end
                endcase
            end else if (w_go) begin
                case (w_act.op)
                    tstty_pkg::OP_CH_DIV: begin
                        r_ph <= w_ch_ph[tstty_pkg::PH_W-1:0];
                        r_pv <= '0;
                    end
                    tstty_pkg::OP_LB_DIV: begin
                        r_pv <= w_lb_pv[tstty_pkg::PV_W-1:0];
                    end
                    tstty_pkg::OP_FINISH: begin
                        r_ph  <= tstty_pkg::sat_ph(w_fin_ph);
                        r_col <= w_fin_col[16] ? '1 : w_fin_col[15:0];
                    end
                    default: begin
                        r_ph <= r_ph;
                    end
                endcase
            end
        end
    end

    // payload and run registers
    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_glyph  <= w_glyph_in;
            r_adv    <= i_in.advance;
            r_styled <= (r_bold || r_italic) && tstty_pkg::is_alnum(w_glyph_in);
        end
        if (w_go && w_act.emit) begin
            r_obyte <= w_byte;
            r_olast <= w_act.last;
            r_obad  <= w_act.bad;
        end
        if (w_go && !w_idle) begin
            if (w_act.dec) begin
                r_cnt <= r_cnt - 5'd1;
            end else begin
                case (w_act.op)
                    tstty_pkg::OP_CH_DIV: begin
                        r_cnt  <= {1'b0, w_d20_q};
                        r_half <= (w_d20_r >= 8'd10);
                        r_up   <= r_pv[8];
                        r_left <= r_ph[9];
                        r_hcnt <= w_d12_q;
                    end
                    tstty_pkg::OP_LB_DIV: begin
                        r_cnt <= {1'b0, w_d20_q};
                    end
                    tstty_pkg::OP_LOAD_H: begin
                        r_cnt <= r_hcnt;
                    end
                    default: begin
                        r_cnt <= r_cnt;
                    end
                endcase
            end
        end
    end

endmodule
